>>> rtl/kce_pkg.sv
// kce_pkg: shared types and constants of the keyframe curve evaluator.
// No dependencies; used by the interfaces and the evaluator unit.
`timescale 1ns / 1ps

package kce_pkg;

  // Data word of times and Q16.16 values
  localparam int WORD_W = 32;
  // Bit counter of the serial multiply and divide
  localparam int CNT_W = $clog2(WORD_W);
  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int KEY_COUNT_W = 7;
  localparam int KEY_INDEX_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_COUNT  = 1'b0,
    CFG_BASE_VALUE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CASE_BASE   = 2'd0,
    CASE_SINGLE = 2'd1,
    CASE_CLAMP  = 2'd2,
    CASE_INTERP = 2'd3
  } case_code_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST,
    ST_LCHK,
    ST_SCAN,
    ST_PREP,
    ST_ABS,
    ST_MUL,
    ST_DIV,
    ST_ADJ,
    ST_DONE
  } state_t;

endpackage

>>> rtl/kce_if.sv
// kce_in_if / kce_out_if: valid-ready channels of the curve evaluator.
// Depends on kce_pkg for field widths.
`timescale 1ns / 1ps

interface kce_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [kce_pkg::KEY_INDEX_W-1:0]      key_index;
  logic [kce_pkg::WORD_W-1:0]           key_time;
  logic signed [kce_pkg::WORD_W-1:0]    key_value;
  logic [kce_pkg::WORD_W-1:0]           query_time;

  modport source (output valid, command, key_index, key_time, key_value, query_time,
                  input ready);
  modport sink   (input valid, command, key_index, key_time, key_value, query_time,
                  output ready);
endinterface

interface kce_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kce_pkg::WORD_W-1:0]    curve_value;
  logic [1:0]                           case_code;

  modport source (output valid, curve_value, case_code, input ready);
  modport sink   (input valid, curve_value, case_code, output ready);
endinterface

>>> rtl/kce_ram.sv
// kce_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module kce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/keyframe_curve_evaluator_unit.sv
// A write beat goes straight into the key table. A query result goes valid from the hand-over
// state: straight from idle in the base case, after a read of the last key for single-key and
// clamp; an interpolated query steps past the keys (one key per cycle, one RAM read port),
// then runs the serial shift-add multiply and the restoring divide before the hand-over.
// The unit takes one item at a time; the next beat is taken once the result goes valid. Reset
// (rst_n low, synchronous) clears the FSM, result valid and configuration, not the table.
`timescale 1ns / 1ps

module keyframe_curve_evaluator_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  kce_in_if.sink                         in_bus,
  kce_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [kce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kce_pkg::WORD_W-1:0]     cfg_wdata
);

  localparam int W  = kce_pkg::WORD_W;
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int CW = (NW > kce_pkg::KEY_COUNT_W) ? NW : kce_pkg::KEY_COUNT_W;

  // Configuration registers
  logic [kce_pkg::KEY_COUNT_W-1:0] key_count_r;
  logic [W-1:0]                    base_value_r;

  // Control state
  kce_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [W-1:0]              qtime_r, qtime_nxt;
  logic [AW-1:0]             lastidx_r, lastidx_nxt;
  logic                      n_one_r, n_one_nxt;
  logic [AW-1:0]             i_r, i_nxt;
  logic [W-1:0]              src_time_r, src_time_nxt;
  logic [W-1:0]              src_val_r, src_val_nxt;
  logic [W-1:0]              dst_time_r, dst_time_nxt;
  logic [W-1:0]              dst_val_r, dst_val_nxt;
  logic [W:0]                diff_r, diff_nxt;
  logic [W-1:0]              mag_r, mag_nxt;
  logic [W-1:0]              span_r, span_nxt;
  logic [W-1:0]              hi_r, hi_nxt;
  logic [W-1:0]              lo_r, lo_nxt;
  logic [kce_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]              res_value_r, res_value_nxt;
  kce_pkg::case_code_t       res_code_r, res_code_nxt;
  logic [W-1:0]              curve_value_r, curve_value_nxt;
  kce_pkg::case_code_t       case_code_r, case_code_nxt;

  // Key table: {time, value} per slot
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*W-1:0]  ram_wdata, ram_rdata;
  logic [W-1:0]    rd_time, rd_val;

  // Combinational helpers
  logic            in_fire;
  logic [CW-1:0]   count_ext;
  logic [NW-1:0]   n_eff;
  logic [W:0]      mul_sum;
  logic [W:0]      div_rem;
  logic [W:0]      div_sub;

  assign in_fire   = in_bus.valid && in_bus.ready;
  assign rd_time   = ram_rdata[2*W-1:W];
  assign rd_val    = ram_rdata[W-1:0];
  assign count_ext = CW'(key_count_r);
  assign n_eff     = (count_ext > CW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(count_ext);

  // Store a keyframe on a write beat; slots beyond the table are dropped
  assign ram_we    = in_fire && (in_bus.command == kce_pkg::CMD_WRITE)
                     && (32'(in_bus.key_index) < MAX_KEYS);
  assign ram_waddr = AW'(in_bus.key_index);
  assign ram_wdata = {in_bus.key_time, in_bus.key_value};

  kce_ram #(
    .WIDTH (2 * W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Serial arithmetic steps
  assign mul_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mag_r} : '0);
  assign div_rem = {hi_r, lo_r[W-1]};
  assign div_sub = div_rem - {1'b0, span_r};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r  <= '0;
      base_value_r <= '0;
    end else if (cfg_we) begin
      unique case (kce_pkg::cfg_reg_t'(cfg_index))
        kce_pkg::CFG_KEY_COUNT:  key_count_r  <= cfg_wdata[kce_pkg::KEY_COUNT_W-1:0];
        kce_pkg::CFG_BASE_VALUE: base_value_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state, datapath and outputs
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    qtime_nxt       = qtime_r;
    lastidx_nxt     = lastidx_r;
    n_one_nxt       = n_one_r;
    i_nxt           = i_r;
    src_time_nxt    = src_time_r;
    src_val_nxt     = src_val_r;
    dst_time_nxt    = dst_time_r;
    dst_val_nxt     = dst_val_r;
    diff_nxt        = diff_r;
    mag_nxt         = mag_r;
    span_nxt        = span_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    cnt_nxt         = cnt_r;
    res_value_nxt   = res_value_r;
    res_code_nxt    = res_code_r;
    curve_value_nxt = curve_value_r;
    case_code_nxt   = case_code_r;
    ram_raddr       = i_r;
    in_bus.ready    = 1'b0;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      kce_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_fire && (in_bus.command == kce_pkg::CMD_QUERY)) begin
          qtime_nxt   = in_bus.query_time;
          lastidx_nxt = AW'(n_eff - NW'(1));
          n_one_nxt   = (n_eff == NW'(1));
          if (n_eff == '0) begin
            res_value_nxt = base_value_r;
            res_code_nxt  = kce_pkg::CASE_BASE;
            state_nxt     = kce_pkg::ST_DONE;
          end else begin
            state_nxt = kce_pkg::ST_LAST;
          end
        end
      end

      // Fetch the last valid key
      kce_pkg::ST_LAST: begin
        ram_raddr = lastidx_r;
        state_nxt = kce_pkg::ST_LCHK;
      end

      // Single key or clamp; else start the scan at slot zero
      kce_pkg::ST_LCHK: begin
        if (n_one_r) begin
          res_value_nxt = rd_val;
          res_code_nxt  = kce_pkg::CASE_SINGLE;
          state_nxt     = kce_pkg::ST_DONE;
        end else if (qtime_r >= rd_time) begin
          res_value_nxt = rd_val;
          res_code_nxt  = kce_pkg::CASE_CLAMP;
          state_nxt     = kce_pkg::ST_DONE;
        end else begin
          ram_raddr    = '0;
          i_nxt        = '0;
          src_time_nxt = '0;
          src_val_nxt  = base_value_r;
          state_nxt    = kce_pkg::ST_SCAN;
        end
      end

      // One key per cycle; the read of the next slot is already in flight
      kce_pkg::ST_SCAN: begin
        ram_raddr = (i_r == lastidx_r) ? i_r : i_r + AW'(1);
        if ((i_r != lastidx_r) && (rd_time <= qtime_r)) begin
          src_time_nxt = rd_time;
          src_val_nxt  = rd_val;
          i_nxt        = i_r + AW'(1);
        end else begin
          dst_time_nxt = rd_time;
          dst_val_nxt  = rd_val;
          state_nxt    = kce_pkg::ST_PREP;
        end
      end

      // Value step, elapsed time and interval length
      kce_pkg::ST_PREP: begin
        diff_nxt  = {dst_val_r[W-1], dst_val_r} - {src_val_r[W-1], src_val_r};
        span_nxt  = dst_time_r - src_time_r;
        lo_nxt    = qtime_r - src_time_r;
        hi_nxt    = '0;
        state_nxt = kce_pkg::ST_ABS;
      end

      kce_pkg::ST_ABS: begin
        mag_nxt   = diff_r[W] ? W'(-diff_r) : diff_r[W-1:0];
        cnt_nxt   = '1;
        state_nxt = kce_pkg::ST_MUL;
      end

      // Shift-add multiply, one bit of the elapsed time per cycle
      kce_pkg::ST_MUL: begin
        hi_nxt  = mul_sum[W:1];
        lo_nxt  = {mul_sum[0], lo_r[W-1:1]};
        cnt_nxt = cnt_r - kce_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          cnt_nxt   = '1;
          state_nxt = kce_pkg::ST_DIV;
        end
      end

      // Restoring divide, one quotient bit per cycle shifted into lo
      kce_pkg::ST_DIV: begin
        if (!div_sub[W]) begin
          hi_nxt = div_sub[W-1:0];
          lo_nxt = {lo_r[W-2:0], 1'b1};
        end else begin
          hi_nxt = div_rem[W-1:0];
          lo_nxt = {lo_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - kce_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = kce_pkg::ST_ADJ;
        end
      end

      // Apply the truncated step in the sign of the value change
      kce_pkg::ST_ADJ: begin
        res_value_nxt = diff_r[W] ? (src_val_r - lo_r) : (src_val_r + lo_r);
        res_code_nxt  = kce_pkg::CASE_INTERP;
        state_nxt     = kce_pkg::ST_DONE;
      end

      // Hand over to the result register when it is free
      kce_pkg::ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          curve_value_nxt = res_value_r;
          case_code_nxt   = res_code_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = kce_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = kce_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kce_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    qtime_r       <= qtime_nxt;
    lastidx_r     <= lastidx_nxt;
    n_one_r       <= n_one_nxt;
    i_r           <= i_nxt;
    src_time_r    <= src_time_nxt;
    src_val_r     <= src_val_nxt;
    dst_time_r    <= dst_time_nxt;
    dst_val_r     <= dst_val_nxt;
    diff_r        <= diff_nxt;
    mag_r         <= mag_nxt;
    span_r        <= span_nxt;
    hi_r          <= hi_nxt;
    lo_r          <= lo_nxt;
    cnt_r         <= cnt_nxt;
    res_value_r   <= res_value_nxt;
    res_code_r    <= res_code_nxt;
    curve_value_r <= curve_value_nxt;
    case_code_r   <= case_code_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.curve_value = curve_value_r;
  assign out_bus.case_code   = case_code_r;

`ifndef SYNTH
  // A new result only comes from the hand-over state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == kce_pkg::ST_DONE)
    else $error("result raised outside hand-over");

  // The multiply always starts with a full bit count
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kce_pkg::ST_ABS |=> state_r == kce_pkg::ST_MUL && cnt_r == '1)
    else $error("multiply started with wrong count");

  // The scan never runs past the last valid key
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kce_pkg::ST_SCAN |-> i_r <= lastidx_r)
    else $error("scan index past last key");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kce_pkg::ST_DIV |-> hi_r < span_r)
    else $error("divide remainder out of range");
`endif

endmodule
